### design/csp_pkg.sv
// Shared types, constants and helpers for the convex support point block.
package csp_pkg;

    localparam int COORD_W    = 32;
    localparam int QUAT_W     = 16;
    localparam int MAT_W      = 30;
    localparam int DOT_W      = 66;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int MARGIN_W   = 31;
    localparam int SEARCH_MAX = 64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_MARGIN       = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [MAT_W-1:0]   mat_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PROD, ST_MATRIX, ST_SWEEP, ST_DRAIN, ST_SCALE, ST_FINISH
    } top_state_t;

    typedef enum logic [2:0] {
        NM_IDLE, NM_SQUARE, NM_SUM, NM_SHIFT, NM_ROOT, NM_PREP, NM_DIVIDE, NM_DONE
    } norm_state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } norm_status_t;

    // clamp a 64-bit signed value into a Q16.16 coordinate
    function automatic coord_t sat_coord(input logic signed [63:0] v);
        coord_t r;
        if (v[63:31] == {33{v[63]}}) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

### design/csp_cell.sv
// One vertex cell of the rotating vertex store.
module csp_cell (
    input  logic            aclk,
    input  logic            load_en,
    input  logic            shift_en,
    input  csp_pkg::coord_t load_vert [3],
    input  csp_pkg::coord_t shift_in  [3],
    output csp_pkg::coord_t vert      [3]
);

    csp_pkg::coord_t vert_reg [3];

    always_ff @(posedge aclk) begin
        if (load_en) begin
            vert_reg <= load_vert;
        end else if (shift_en) begin
            vert_reg <= shift_in;
        end
    end

    assign vert = vert_reg;

endmodule

### design/csp_xform.sv
// Transform, dot product and running maximum pipeline fed from the cell ring head.
module csp_xform (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [5:0]      in_idx,
    input  csp_pkg::coord_t in_vert [3],
    input  csp_pkg::mat_t   mat     [3][3],
    input  csp_pkg::coord_t dir     [3],
    input  csp_pkg::coord_t pos     [3],
    output logic            busy,
    output csp_pkg::coord_t best_pt [3],
    output logic [5:0]      best_idx
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [5:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;

    logic signed [61:0] prod_reg [3][3];
    logic signed [63:0] acc_reg  [3];
    logic signed [63:0] dp_reg   [3];
    logic signed [63:0] rnd      [3];
    csp_pkg::coord_t    pt3_reg  [3];
    csp_pkg::coord_t    pt4_reg  [3];
    csp_pkg::coord_t    pt5_reg  [3];
    logic signed [csp_pkg::DOT_W-1:0] dot_reg, best_dot_reg;
    csp_pkg::coord_t    best_pt_reg [3];
    logic [5:0]         best_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // round half up from Q.40 to Q16.16, then translate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rnd[r] = ((acc_reg[r] + 64'sd8388608) >>> 24) + 64'(pos[r]);
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        idx5_reg <= idx4_reg;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[r][c] <= 62'(mat[r][c]) * 62'(in_vert[c]);
            end
            acc_reg[r] <= 64'(prod_reg[r][0]) + 64'(prod_reg[r][1]) + 64'(prod_reg[r][2]);
            pt3_reg[r] <= csp_pkg::sat_coord(rnd[r]);
            dp_reg[r]  <= 64'(dir[r]) * 64'(pt3_reg[r]);
            pt4_reg[r] <= pt3_reg[r];
            pt5_reg[r] <= pt4_reg[r];
        end
        dot_reg <= 66'(dp_reg[0]) + 66'(dp_reg[1]) + 66'(dp_reg[2]);
        // strictly greater keeps the earliest vertex on ties
        if (v5_reg && (idx5_reg == 6'd0 || dot_reg > best_dot_reg)) begin
            best_dot_reg <= dot_reg;
            best_idx_reg <= idx5_reg;
            best_pt_reg  <= pt5_reg;
        end
    end

    assign busy     = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign best_pt  = best_pt_reg;
    assign best_idx = best_idx_reg;

endmodule

### design/csp_norm.sv
// Direction normalizer: sum of squares, scaling, integer square root, three dividers.
module csp_norm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  csp_pkg::coord_t       dir    [3],
    output csp_pkg::norm_status_t status,
    output csp_pkg::coord_t       unit   [3]
);

    csp_pkg::norm_state_t state_reg, state_next;

    csp_pkg::coord_t   d_reg   [3];
    logic [62:0]       sq_reg  [3];
    logic [61:0]       t_reg;
    logic signed [5:0] j_reg;
    logic [61:0]       x_reg, r_reg;
    logic [4:0]        k_reg;
    logic              zero_reg;
    logic [30:0]       rem_reg [3];
    logic [31:0]       nq_reg  [3];

    logic [63:0] s_sum;
    logic [62:0] bitv, rb;
    logic        ge_root;
    logic [31:0] mag     [3];
    logic [5:0]  sh;
    logic [61:0] numer   [3];
    logic [31:0] rem2    [3];
    logic        ge_div  [3];

    always_comb begin
        s_sum   = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        bitv    = 63'(1) << {k_reg, 1'b0};
        rb      = {1'b0, r_reg} + bitv;
        ge_root = {1'b0, x_reg} >= rb;
        sh      = 6'(7'sd30 + 7'(j_reg));
        for (int c = 0; c < 3; c++) begin
            mag[c]    = d_reg[c][31] ? 32'(-d_reg[c]) : 32'(d_reg[c]);
            // rounding bias of half the divisor folded into the dividend
            numer[c]  = 62'(64'(mag[c]) << sh) + 62'(r_reg[30:1]);
            rem2[c]   = {rem_reg[c], nq_reg[c][31]};
            ge_div[c] = rem2[c] >= {1'b0, r_reg[30:0]};
            unit[c]   = d_reg[c][31] ? -$signed(nq_reg[c]) : $signed(nq_reg[c]);
        end
    end

    always_comb begin
        state_next = state_reg;
        if (start) begin
            state_next = csp_pkg::NM_SQUARE;
        end else begin
            unique case (state_reg)
                csp_pkg::NM_SQUARE: state_next = csp_pkg::NM_SUM;
                csp_pkg::NM_SUM: begin
                    if (s_sum == 64'd0) begin
                        state_next = csp_pkg::NM_DONE;
                    end else if (s_sum[63:62] != 2'b00) begin
                        state_next = csp_pkg::NM_ROOT;
                    end else begin
                        state_next = csp_pkg::NM_SHIFT;
                    end
                end
                csp_pkg::NM_SHIFT: begin
                    if (t_reg[61:60] != 2'b00) begin
                        state_next = csp_pkg::NM_ROOT;
                    end
                end
                csp_pkg::NM_ROOT: begin
                    if (k_reg == 5'd0) begin
                        state_next = csp_pkg::NM_PREP;
                    end
                end
                csp_pkg::NM_PREP: state_next = csp_pkg::NM_DIVIDE;
                csp_pkg::NM_DIVIDE: begin
                    if (k_reg == 5'd0) begin
                        state_next = csp_pkg::NM_DONE;
                    end
                end
                default: state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csp_pkg::NM_IDLE;
            k_reg     <= 5'd30;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == csp_pkg::NM_ROOT || state_reg == csp_pkg::NM_DIVIDE) begin
                k_reg <= k_reg - 5'd1;
            end else if (state_reg == csp_pkg::NM_PREP) begin
                k_reg <= 5'd31;
            end else begin
                k_reg <= 5'd30;
            end
            if (start) begin
                zero_reg <= 1'b0;
            end else if (state_reg == csp_pkg::NM_SUM && s_sum == 64'd0) begin
                zero_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg <= dir;
        end
        case (state_reg)
            csp_pkg::NM_SQUARE: begin
                for (int c = 0; c < 3; c++) begin
                    sq_reg[c] <= 63'(64'(d_reg[c]) * 64'(d_reg[c]));
                end
            end
            csp_pkg::NM_SUM: begin
                r_reg <= '0;
                if (s_sum[63:62] != 2'b00) begin
                    t_reg <= s_sum[63:2];
                    x_reg <= s_sum[63:2];
                    j_reg <= -6'sd1;
                end else begin
                    t_reg <= s_sum[61:0];
                    x_reg <= s_sum[61:0];
                    j_reg <= 6'sd0;
                end
            end
            csp_pkg::NM_SHIFT: begin
                x_reg <= t_reg;
                r_reg <= '0;
                if (t_reg[61:60] == 2'b00) begin
                    if (t_reg[61:52] == 10'd0) begin
                        t_reg <= {t_reg[53:0], 8'd0};
                        j_reg <= j_reg + 6'sd4;
                    end else begin
                        t_reg <= {t_reg[59:0], 2'd0};
                        j_reg <= j_reg + 6'sd1;
                    end
                end
            end
            csp_pkg::NM_ROOT: begin
                if (ge_root) begin
                    x_reg <= 62'({1'b0, x_reg} - rb);
                    r_reg <= 62'(({1'b0, r_reg} >> 1) + bitv);
                end else begin
                    r_reg <= r_reg >> 1;
                end
            end
            csp_pkg::NM_PREP: begin
                for (int c = 0; c < 3; c++) begin
                    rem_reg[c] <= {1'b0, numer[c][61:32]};
                    nq_reg[c]  <= numer[c][31:0];
                end
            end
            csp_pkg::NM_DIVIDE: begin
                for (int c = 0; c < 3; c++) begin
                    rem_reg[c] <= ge_div[c] ? 31'(rem2[c] - {1'b0, r_reg[30:0]})
                                            : rem2[c][30:0];
                    nq_reg[c]  <= {nq_reg[c][30:0], ge_div[c]};
                end
            end
            default: begin
            end
        endcase
    end

    assign status.done = (state_reg == csp_pkg::NM_DONE);
    assign status.zero = zero_reg;

endmodule

### design/convex_support_point.sv
// Top level of the convex support point block: cell ring, FSM, margin stage, ports.
//
// Input channel (s_*): a load request (operation 0) writes one vertex into the
// slot given; loads stream at one per cycle while the block is idle. A
// query request (operation 1) carries a direction, a unit quaternion and a
// translation and yields one result on the m_* channel: the transformed vertex
// with the greatest dot product (first on ties) plus the normalized direction
// times margin. A zero direction adds no margin and sets m_zero_direction.
// With 64 cells a query runs two setup states (product, matrix), the ring
// sweep over every cell and the 5-stage transform pipeline, while the
// direction normalizer (square, sum, scaling, 31-step square root, dividers)
// runs alongside; the result waits for the longer path. s_ready returns with
// m_valid, when the result is loaded into the output register. One request
// is in flight at a time. The result sits in an output register; while the
// receiver stalls, loads and the next query are still accepted, and a
// finished query waits for the slot. Configuration (cfg_*) is to be written by
// the user only while idle; the block does not enforce it. Reset sets vertex_count
// to 1 and margin to 0; the vertex store is not cleared and must be loaded.
module convex_support_point #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [csp_pkg::MARGIN_W-1:0]    cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [csp_pkg::SLOT_W-1:0]      s_slot,
    input  csp_pkg::coord_t                 s_vec_x,
    input  csp_pkg::coord_t                 s_vec_y,
    input  csp_pkg::coord_t                 s_vec_z,
    input  csp_pkg::quat_t                  s_quat_w,
    input  csp_pkg::quat_t                  s_quat_x,
    input  csp_pkg::quat_t                  s_quat_y,
    input  csp_pkg::quat_t                  s_quat_z,
    input  csp_pkg::coord_t                 s_pos_x,
    input  csp_pkg::coord_t                 s_pos_y,
    input  csp_pkg::coord_t                 s_pos_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output csp_pkg::coord_t                 m_point_x,
    output csp_pkg::coord_t                 m_point_y,
    output csp_pkg::coord_t                 m_point_z,
    output logic [csp_pkg::SLOT_W-1:0]      m_best_vertex,
    output logic                            m_zero_direction
);

    localparam int CELLS = (MAX_VERTICES < csp_pkg::SEARCH_MAX) ? MAX_VERTICES
                                                                : csp_pkg::SEARCH_MAX;
    localparam int IDX_W = $clog2(CELLS);
    localparam logic signed [33:0] ONE_Q28 = 34'sd1 <<< 28;

    function automatic csp_pkg::mat_t mat_round(input logic signed [33:0] raw);
        return csp_pkg::mat_t'((raw + 34'sd8) >>> 4);
    endfunction

    csp_pkg::top_state_t state_reg, state_next;

    logic [csp_pkg::COUNT_W-1:0]  vcount_reg;
    logic [csp_pkg::MARGIN_W-1:0] margin_reg;
    logic [IDX_W-1:0]             rot_reg;
    logic                         m_valid_reg;

    csp_pkg::coord_t  s_vec    [3];
    csp_pkg::coord_t  dir_reg  [3];
    csp_pkg::coord_t  pos_reg  [3];
    csp_pkg::quat_t   quat_reg [4];
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    csp_pkg::mat_t    mat_reg  [3][3];
    logic signed [63:0] off_prod_reg [3];
    logic signed [63:0] off      [3];
    csp_pkg::coord_t  fin_pt   [3];
    csp_pkg::coord_t  out_pt_reg [3];
    logic [5:0]       out_idx_reg;
    logic             out_zero_reg;

    csp_pkg::coord_t  cell_vert [CELLS][3];

    logic load_fire, query_fire, out_free, fin_fire, shift_en, feed_valid;
    logic [csp_pkg::COUNT_W-1:0] eff_count;

    logic                  xf_busy;
    csp_pkg::coord_t       xf_best_pt [3];
    logic [5:0]            xf_best_idx;
    csp_pkg::norm_status_t nstat;
    csp_pkg::coord_t       nunit [3];

    assign s_vec[0] = s_vec_x;
    assign s_vec[1] = s_vec_y;
    assign s_vec[2] = s_vec_z;

    assign s_ready    = (state_reg == csp_pkg::ST_IDLE);
    assign load_fire  = s_valid && s_ready && (s_operation == csp_pkg::OP_LOAD);
    assign query_fire = s_valid && s_ready && (s_operation == csp_pkg::OP_QUERY);
    assign out_free   = !m_valid_reg || m_ready;
    assign fin_fire   = (state_reg == csp_pkg::ST_FINISH) && out_free;
    assign shift_en   = (state_reg == csp_pkg::ST_SWEEP);

    always_comb begin
        eff_count = (vcount_reg == '0) ? 7'd1 : vcount_reg;
        if (eff_count > 7'(CELLS)) begin
            eff_count = 7'(CELLS);
        end
    end

    assign feed_valid = shift_en && (7'(rot_reg) < eff_count);

    // ring of cells; cell 0 is the head that feeds the pipeline
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        csp_cell u_cell (
            .aclk      (aclk),
            .load_en   (load_fire && (s_slot == 6'(i))),
            .shift_en  (shift_en),
            .load_vert (s_vec),
            .shift_in  (cell_vert[(i + 1) % CELLS]),
            .vert      (cell_vert[i])
        );
    end

    csp_xform u_xform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (feed_valid),
        .in_idx   (6'(rot_reg)),
        .in_vert  (cell_vert[0]),
        .mat      (mat_reg),
        .dir      (dir_reg),
        .pos      (pos_reg),
        .busy     (xf_busy),
        .best_pt  (xf_best_pt),
        .best_idx (xf_best_idx)
    );

    csp_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (query_fire),
        .dir     (s_vec),
        .status  (nstat),
        .unit    (nunit)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csp_pkg::ST_IDLE: begin
                if (query_fire) begin
                    state_next = csp_pkg::ST_PROD;
                end
            end
            csp_pkg::ST_PROD:   state_next = csp_pkg::ST_MATRIX;
            csp_pkg::ST_MATRIX: state_next = csp_pkg::ST_SWEEP;
            csp_pkg::ST_SWEEP: begin
                if (rot_reg == IDX_W'(CELLS - 1)) begin
                    state_next = csp_pkg::ST_DRAIN;
                end
            end
            csp_pkg::ST_DRAIN: begin
                if (!xf_busy && nstat.done) begin
                    state_next = csp_pkg::ST_SCALE;
                end
            end
            csp_pkg::ST_SCALE: state_next = csp_pkg::ST_FINISH;
            csp_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = csp_pkg::ST_IDLE;
                end
            end
            default: state_next = csp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= csp_pkg::ST_IDLE;
            rot_reg     <= '0;
            m_valid_reg <= 1'b0;
            vcount_reg  <= 7'd1;
            margin_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (shift_en) begin
                rot_reg <= rot_reg + IDX_W'(1);
            end else begin
                rot_reg <= '0;
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    csp_pkg::CFG_VERTEX_COUNT: vcount_reg <= cfg_data[csp_pkg::COUNT_W-1:0];
                    csp_pkg::CFG_MARGIN:       margin_reg <= cfg_data;
                    default:                   margin_reg <= margin_reg;
                endcase
            end
        end
    end

    // offset = u * margin / 2^30, rounded half away from zero
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (off_prod_reg[c] >= 0) begin
                off[c] = (off_prod_reg[c] + 64'sd536870912) >>> 30;
            end else begin
                off[c] = -((-off_prod_reg[c] + 64'sd536870912) >>> 30);
            end
            fin_pt[c] = csp_pkg::sat_coord(64'(xf_best_pt[c]) + off[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (query_fire) begin
            dir_reg     <= s_vec;
            pos_reg[0]  <= s_pos_x;
            pos_reg[1]  <= s_pos_y;
            pos_reg[2]  <= s_pos_z;
            quat_reg[0] <= s_quat_w;
            quat_reg[1] <= s_quat_x;
            quat_reg[2] <= s_quat_y;
            quat_reg[3] <= s_quat_z;
        end
        if (state_reg == csp_pkg::ST_PROD) begin
            xx_reg <= 32'(quat_reg[1]) * 32'(quat_reg[1]);
            yy_reg <= 32'(quat_reg[2]) * 32'(quat_reg[2]);
            zz_reg <= 32'(quat_reg[3]) * 32'(quat_reg[3]);
            xy_reg <= 32'(quat_reg[1]) * 32'(quat_reg[2]);
            xz_reg <= 32'(quat_reg[1]) * 32'(quat_reg[3]);
            yz_reg <= 32'(quat_reg[2]) * 32'(quat_reg[3]);
            wx_reg <= 32'(quat_reg[0]) * 32'(quat_reg[1]);
            wy_reg <= 32'(quat_reg[0]) * 32'(quat_reg[2]);
            wz_reg <= 32'(quat_reg[0]) * 32'(quat_reg[3]);
        end
        if (state_reg == csp_pkg::ST_MATRIX) begin
            mat_reg[0][0] <= mat_round(ONE_Q28 - ((34'(yy_reg) + 34'(zz_reg)) <<< 1));
            mat_reg[0][1] <= mat_round((34'(xy_reg) - 34'(wz_reg)) <<< 1);
            mat_reg[0][2] <= mat_round((34'(xz_reg) + 34'(wy_reg)) <<< 1);
            mat_reg[1][0] <= mat_round((34'(xy_reg) + 34'(wz_reg)) <<< 1);
            mat_reg[1][1] <= mat_round(ONE_Q28 - ((34'(xx_reg) + 34'(zz_reg)) <<< 1));
            mat_reg[1][2] <= mat_round((34'(yz_reg) - 34'(wx_reg)) <<< 1);
            mat_reg[2][0] <= mat_round((34'(xz_reg) - 34'(wy_reg)) <<< 1);
            mat_reg[2][1] <= mat_round((34'(yz_reg) + 34'(wx_reg)) <<< 1);
            mat_reg[2][2] <= mat_round(ONE_Q28 - ((34'(xx_reg) + 34'(yy_reg)) <<< 1));
        end
        if (state_reg == csp_pkg::ST_SCALE) begin
            for (int c = 0; c < 3; c++) begin
                off_prod_reg[c] <= nstat.zero ? 64'sd0
                                 : 64'(nunit[c]) * 64'($signed({1'b0, margin_reg}));
            end
        end
        if (fin_fire) begin
            out_pt_reg   <= fin_pt;
            out_idx_reg  <= xf_best_idx;
            out_zero_reg <= nstat.zero;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_point_x        = out_pt_reg[0];
    assign m_point_y        = out_pt_reg[1];
    assign m_point_z        = out_pt_reg[2];
    assign m_best_vertex    = out_idx_reg;
    assign m_zero_direction = out_zero_reg;

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        query_fire |=> state_reg == csp_pkg::ST_PROD)
        else $error("query did not enter setup");

    a_norm_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == csp_pkg::ST_SCALE |-> nstat.done)
        else $error("margin stage entered before normalizer finished");

    a_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == csp_pkg::ST_IDLE |-> !xf_busy)
        else $error("transform pipeline busy while idle");

    a_zero_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_direction |-> m_best_vertex == 6'd0)
        else $error("zero direction must select the first vertex");

endmodule

### dv/tb_convex_support_point.sv
// Self-checking testbench for the convex support point block.
`timescale 1ns / 1ps

module tb_convex_support_point;

    localparam int STORE_DEPTH = 64;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    typedef struct {
        logic        op;
        logic [5:0]  slot;
        longint      vec[3];
        longint      quat[4];
        longint      pos[3];
    } request_t;

    typedef struct {
        longint     point[3];
        int         best;
        bit         zero;
    } support_t;

    // Support mapping predictor plus ordered store of expected results.
    class support_scoreboard;
        longint      store[STORE_DEPTH][3];
        longint      count_reg;
        longint      margin_reg;
        support_t    expected_q[$];
        int          errors;
        int          checked;
        int          loads;
        int          zero_dirs;

        function new();
            count_reg = 1;
            margin_reg = 0;
            errors = 0;
            checked = 0;
            loads = 0;
            zero_dirs = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic idx, longint val);
            if (idx == csp_pkg::CFG_VERTEX_COUNT) count_reg = val & 64'h7f;
            else margin_reg = val & 64'h7fff_ffff;
        endfunction

        function longint clamp32(longint v);
            if (v > COORD_MAX) return COORD_MAX;
            if (v < COORD_MIN) return COORD_MIN;
            return v;
        endfunction

        // half away from zero, b > 0
        function longint div_half_away(longint a, longint b);
            if (a >= 0) return (a + b / 2) / b;
            return -((-a + b / 2) / b);
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r;
            longint unsigned bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= r + bitv) begin
                    x -= r + bitv;
                    r = (r >> 1) + bitv;
                end else begin
                    r >>= 1;
                end
                bitv >>= 2;
            end
            return r;
        endfunction

        function support_t support_of(request_t rq);
            support_t            res;
            longint              rot[3][3];
            longint              q0, q1, q2, q3, acc, u, off;
            longint              pt[3];
            logic signed [127:0] dot, best_dot;
            longint unsigned     sq, t, n;
            int                  n_search, j;
            q0 = rq.quat[0]; q1 = rq.quat[1]; q2 = rq.quat[2]; q3 = rq.quat[3];
            rot[0][0] = (64'sd1 <<< 28) - 2 * (q2 * q2 + q3 * q3);
            rot[0][1] = 2 * (q1 * q2 - q0 * q3);
            rot[0][2] = 2 * (q1 * q3 + q0 * q2);
            rot[1][0] = 2 * (q1 * q2 + q0 * q3);
            rot[1][1] = (64'sd1 <<< 28) - 2 * (q1 * q1 + q3 * q3);
            rot[1][2] = 2 * (q2 * q3 - q0 * q1);
            rot[2][0] = 2 * (q1 * q3 - q0 * q2);
            rot[2][1] = 2 * (q2 * q3 + q0 * q1);
            rot[2][2] = (64'sd1 <<< 28) - 2 * (q1 * q1 + q2 * q2);
            foreach (rot[r, c]) rot[r][c] = (rot[r][c] + 8) >>> 4;

            n_search = (count_reg == 0) ? 1 : (count_reg > 64 ? 64 : int'(count_reg));
            res.best = 0;
            best_dot = 0;
            for (int i = 0; i < n_search; i++) begin
                dot = 0;
                for (int r = 0; r < 3; r++) begin
                    acc = 0;
                    for (int c = 0; c < 3; c++) acc += rot[r][c] * store[i][c];
                    pt[r] = clamp32(((acc + (64'sd1 <<< 23)) >>> 24) + rq.pos[r]);
                    dot = dot + rq.vec[r] * pt[r];
                end
                if (i == 0 || dot > best_dot) begin
                    best_dot = dot;
                    res.best = i;
                    res.point = pt;
                end
            end

            sq = 0;
            for (int c = 0; c < 3; c++) sq += longint'(rq.vec[c] * rq.vec[c]);
            res.zero = (sq == 0);
            if (!res.zero) begin
                j = 0;
                t = sq;
                if (t >= (64'd1 << 62)) begin
                    t >>= 2;
                    j = -1;
                end else begin
                    while (t < (64'd1 << 60)) begin
                        t <<= 2;
                        j++;
                    end
                end
                n = root_floor(t);
                for (int c = 0; c < 3; c++) begin
                    u = div_half_away(rq.vec[c] * (64'sd1 <<< (30 + j)), longint'(n));
                    off = div_half_away(u * margin_reg, 64'sd1 <<< 30);
                    res.point[c] = clamp32(res.point[c] + off);
                end
            end
            return res;
        endfunction

        function void note_request(request_t rq);
            if (rq.op == csp_pkg::OP_LOAD) begin
                loads++;
                if (rq.slot < STORE_DEPTH)
                    for (int c = 0; c < 3; c++) store[rq.slot][c] = rq.vec[c];
            end else begin
                expected_q = {expected_q, support_of(rq)};
            end
        endfunction

        task check_result(csp_pkg::coord_t px, csp_pkg::coord_t py, csp_pkg::coord_t pz,
                          logic [5:0] bv, logic zd);
            support_t e;
            if (expected_q.size() == 0) begin
                report("result with no query outstanding");
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.zero) zero_dirs++;
            if (px !== e.point[0][31:0])
                report($sformatf("point_x %0d, want %0d", px, e.point[0]));
            if (py !== e.point[1][31:0])
                report($sformatf("point_y %0d, want %0d", py, e.point[1]));
            if (pz !== e.point[2][31:0])
                report($sformatf("point_z %0d, want %0d", pz, e.point[2]));
            if (bv !== e.best[5:0])
                report($sformatf("best_vertex %0d, want %0d", bv, e.best));
            if (zd !== e.zero)
                report($sformatf("zero_direction %0b, want %0b", zd, e.zero));
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [csp_pkg::MARGIN_W-1:0]  cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_operation;
    logic [csp_pkg::SLOT_W-1:0]    s_slot;
    csp_pkg::coord_t               s_vec_x, s_vec_y, s_vec_z;
    csp_pkg::quat_t                s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    csp_pkg::coord_t               s_pos_x, s_pos_y, s_pos_z;
    logic                          m_valid;
    logic                          m_ready;
    csp_pkg::coord_t               m_point_x, m_point_y, m_point_z;
    logic [csp_pkg::SLOT_W-1:0]    m_best_vertex;
    logic                          m_zero_direction;

    support_scoreboard    sb;
    bit                   steady;
    int                   stall_left;
    int                   queries_sent;

    convex_support_point #(.MAX_VERTICES(STORE_DEPTH)) uut (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        s_valid = 1'b0; s_operation = csp_pkg::OP_LOAD; s_slot = '0;
        s_vec_x = '0; s_vec_y = '0; s_vec_z = '0;
        s_quat_w = '0; s_quat_x = '0; s_quat_y = '0; s_quat_z = '0;
        s_pos_x = '0; s_pos_y = '0; s_pos_z = '0;
        m_ready = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= idle_gap();
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_point_x, m_point_y, m_point_z, m_best_vertex, m_zero_direction);
    end

    task automatic write_reg(logic idx, longint val);
        s_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[csp_pkg::MARGIN_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send(request_t rq);
        int gap;
        s_valid <= 1'b1;
        s_operation <= rq.op;
        s_slot <= rq.slot;
        s_vec_x <= rq.vec[0]; s_vec_y <= rq.vec[1]; s_vec_z <= rq.vec[2];
        s_quat_w <= rq.quat[0]; s_quat_x <= rq.quat[1];
        s_quat_y <= rq.quat[2]; s_quat_z <= rq.quat[3];
        s_pos_x <= rq.pos[0]; s_pos_y <= rq.pos[1]; s_pos_z <= rq.pos[2];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(rq);
        if (rq.op == csp_pkg::OP_QUERY) queries_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // wait for every outstanding query, then for the pipeline to go quiet
    task automatic drain();
        int waited;
        waited = 0;
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (sb.expected_q.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (150) @(posedge aclk);
    endtask

    function automatic longint pick_coord(int narrow);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return COORD_MAX;
        if (r == 1) return COORD_MIN;
        if (r == 2) return 0;
        if (r == 3) return -1;
        if (r < 8 + narrow) return longint'($signed($urandom_range(0, 32'h00ff_ffff))) -
                                   longint'(32'h0080_0000);
        return longint'($signed($urandom()));
    endfunction

    function automatic request_t make_load(int slot, longint x, longint y, longint z);
        request_t rq;
        rq.op = csp_pkg::OP_LOAD;
        rq.slot = slot[5:0];
        rq.vec = '{x, y, z};
        rq.quat = '{longint'($signed(16'($urandom()))), longint'($signed(16'($urandom()))),
                    longint'($signed(16'($urandom()))), longint'($signed(16'($urandom())))};
        rq.pos = '{pick_coord(0), pick_coord(0), pick_coord(0)};
        return rq;
    endfunction

    function automatic request_t make_query(longint dx, longint dy, longint dz,
                                            longint qw, longint qx, longint qy, longint qz,
                                            longint px, longint py, longint pz);
        request_t rq;
        rq.op = csp_pkg::OP_QUERY;
        rq.slot = 6'($urandom());
        rq.vec = '{dx, dy, dz};
        rq.quat = '{qw, qx, qy, qz};
        rq.pos = '{px, py, pz};
        return rq;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int r;
        longint qv[4];
        r = $urandom_range(0, 99);
        if (r < 45)
            return make_load($urandom_range(0, STORE_DEPTH - 1),
                             pick_coord(6), pick_coord(6), pick_coord(6));
        r = $urandom_range(0, 9);
        if (r < 3) qv = '{16384, 0, 0, 0};
        else if (r < 5) qv = '{0, 16384, 0, 0};
        else if (r < 6) qv = '{11585, 0, 0, 11585};
        else foreach (qv[k]) qv[k] = longint'($signed(16'($urandom())));
        rq = make_query(pick_coord(4), pick_coord(4), pick_coord(4), qv[0], qv[1], qv[2], qv[3],
                        pick_coord(6), pick_coord(6), pick_coord(6));
        if ($urandom_range(0, 24) == 0) rq.vec = '{0, 0, 0};
        return rq;
    endfunction

    initial begin
        longint count_set[6];
        longint margin_set[6];
        int     phase_items;
        sb = new();
        steady = 1'b0;
        queries_sent = 0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every slot gets the same vertex: all queries tie, first slot wins
        for (int i = 0; i < STORE_DEPTH; i++) send(make_load(i, 65536, -65536, 131072));
        write_reg(csp_pkg::CFG_VERTEX_COUNT, 64);
        write_reg(csp_pkg::CFG_MARGIN, 32'h0001_0000);
        send(make_query(65536, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
        send(make_query(0, 0, 0, 16384, 0, 0, 0, 100, -100, 7));
        drain();

        // distinct extremes in the first slots
        send(make_load(0, COORD_MAX, COORD_MAX, COORD_MAX));
        send(make_load(1, COORD_MIN, COORD_MIN, COORD_MIN));
        send(make_load(2, COORD_MAX, COORD_MIN, 0));
        send(make_load(3, -1, 0, 1));
        write_reg(csp_pkg::CFG_VERTEX_COUNT, 4);
        write_reg(csp_pkg::CFG_MARGIN, 32'h7fff_ffff);
        send(make_query(COORD_MAX, COORD_MAX, COORD_MAX, 16384, 0, 0, 0, 0, 0, 0));
        send(make_query(COORD_MIN, COORD_MIN, COORD_MIN, 16384, 0, 0, 0, 0, 0, 0));
        send(make_query(1, 0, 0, -32768, -32768, -32768, -32768, COORD_MAX, COORD_MIN, 0));
        send(make_query(0, 0, -1, 32767, 32767, 32767, 32767, COORD_MIN, COORD_MAX, -1));
        send(make_query(0, 0, 0, 0, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MIN));
        send(make_query(-65536, 65536, 3, 0, 0, 16384, 0, 12345, -54321, 0));
        drain();
        write_reg(csp_pkg::CFG_VERTEX_COUNT, 0);
        send(make_query(5, -7, 9, 16384, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(csp_pkg::CFG_VERTEX_COUNT, 127);
        send(make_query(-5, 7, 9, 0, 0, 0, 16384, 0, 0, 0));
        drain();

        count_set  = '{64, 1, 0, 127, 0, 64};
        margin_set = '{0, 32'h7fff_ffff, 65536, 0, 0, 32'h7fff_ffff};
        count_set[4]  = $urandom_range(2, 63);
        margin_set[4] = $urandom_range(0, 32'h7fff_ffff);
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(csp_pkg::CFG_VERTEX_COUNT, count_set[ph]);
            write_reg(csp_pkg::CFG_MARGIN, margin_set[ph]);
            steady = (ph == 2);
            phase_items = (ph == 2) ? 150 : 210;
            for (int n = 0; n < phase_items; n++) send(random_request());
            drain();
        end

        $display("Ran %0d loads and %0d queries across many vertex count and margin settings",
                 sb.loads, queries_sent);
        $display("Checked %0d support results, %0d with a zero direction", sb.checked,
                 sb.zero_dirs);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("convex_support_point verification clean");
        end else begin
            if (sb.expected_q.size() != 0) sb.report("queries left without a result");
            $display("convex_support_point verification failed");
        end
        $finish;
    end

    initial begin
        #(64'd1500000 * 20);
        $display("convex_support_point verification failed");
        $finish;
    end

endmodule
